### rtl/gyro_bias_glitch_average_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gyro bias, glitch and average unit
// Immediate-implication and next-cycle-implication checks, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef GYRO_BIAS_GLITCH_AVERAGE_UNIT_ASSERT_SVH
`define GYRO_BIAS_GLITCH_AVERAGE_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GBGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbga: same-cycle check failed");
// next-cycle implication
`define GBGA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbga: next-cycle check failed");
`else
`define GBGA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GBGA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/gbga_pkg.sv
// ----------------------------------------------------------------------------
// gbga_pkg
// Shared types and constants for the gyro bias, glitch and average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbga_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;

    localparam int RAW_W        = 16;
    localparam int CAL_CNT_W    = 10;
    localparam int CAL_SAMPLES  = 512;
    localparam int CAL_SUM_W    = 32;
    localparam int CAL_SHIFT    = 9;
    localparam int GLITCH_LIMIT = 800;

    // x*7/10: multiply by 7, then divide by 10 via reciprocal 2^23/10 rounded up
    localparam int ROT_NUM   = 7;
    localparam int ROT_RECIP = 838861;
    localparam int ROT_SHIFT = 23;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;
    localparam int AVG_LEN_W     = 4;
    localparam int AVG_LEN_RESET = 4;
    localparam int ROT_MODE_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_ENABLE  = 2'd0,
        CFG_AVG_LENGTH  = 2'd1,
        CFG_ROTATE_MODE = 2'd2
    } cfg_reg_t;

    typedef enum logic [ROT_MODE_W-1:0] {
        ROT_NONE  = 2'd0,
        ROT_LEFT  = 2'd1,
        ROT_RIGHT = 2'd2
    } rot_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CLAMP,
        ST_UPD,
        ST_DIV,
        ST_FIN,
        ST_ROT1,
        ST_ROT2
    } state_t;

    typedef struct packed {
        logic accept;
        logic cal_load;
        logic cal_clear;
        logic clamp;
        logic win_update;
        logic div_step;
        logic finish;
        logic avg_on;
    } lane_ctrl_t;

    typedef struct packed {
        logic                    start_calibration;
        logic signed [RAW_W-1:0] raw_roll;
        logic signed [RAW_W-1:0] raw_pitch;
        logic signed [RAW_W-1:0] raw_yaw;
    } in_word_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] rate_roll;
        logic signed [RAW_W-1:0] rate_pitch;
        logic signed [RAW_W-1:0] rate_yaw;
        logic                    calibrating;
    } out_word_t;

endpackage

`default_nettype wire

### rtl/gbga_ram.sv
// ----------------------------------------------------------------------------
// gbga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbga_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  var logic             clk,
    input  var logic             we,
    input  var logic [AW-1:0]    waddr,
    input  var logic [WIDTH-1:0] wdata,
    input  var logic             re,
    input  var logic [AW-1:0]    raddr,
    output logic     [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/gbga_lane.sv
// ----------------------------------------------------------------------------
// gbga_lane
// One axis: bias calibration, glitch clamp, moving-average window and a
// bit-serial divider for the window mean.
// ----------------------------------------------------------------------------
`default_nettype none

module gbga_lane #(
    parameter int WINDOW_DEPTH = gbga_pkg::WINDOW_DEPTH_DEF,
    localparam int ADDR_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
    localparam int LEN_W       = $clog2(WINDOW_DEPTH + 1)
) (
    input  var logic                               clk,
    input  var logic                               rst_n,
    input  var gbga_pkg::lane_ctrl_t               ctrl,
    input  var logic signed [gbga_pkg::RAW_W-1:0]  raw,
    input  var logic [LEN_W-1:0]                   len,
    input  var logic [ADDR_W-1:0]                  win_addr,
    input  var logic                               old_valid,
    output logic signed [gbga_pkg::RAW_W-1:0]      rate
);
    import gbga_pkg::*;

    localparam int MAG_W = RAW_W + $clog2(WINDOW_DEPTH);
    localparam int SUM_W = MAG_W + 1;

    logic        [CAL_SUM_W-1:0] cal_sum_reg;
    logic        [CAL_SUM_W-1:0] cal_sum_next;
    logic signed [RAW_W-1:0]     bias_reg;
    logic signed [RAW_W-1:0]     prev_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [RAW_W-1:0]     raw_reg;
    logic signed [RAW_W-1:0]     v_reg;
    logic        [MAG_W-1:0]     dq_reg;
    logic        [LEN_W-1:0]     rem_reg;
    logic                        neg_reg;

    logic signed [RAW_W-1:0]     diff;
    logic signed [RAW_W+1:0]     diff_x;
    logic signed [RAW_W+1:0]     lo;
    logic signed [RAW_W+1:0]     hi;
    logic signed [RAW_W+1:0]     clamp_x;
    logic        [RAW_W-1:0]     rdata;
    logic signed [RAW_W-1:0]     old_val;
    logic signed [SUM_W-1:0]     sum_next;
    logic        [SUM_W-1:0]     mag_full;
    logic        [LEN_W:0]       trial;
    logic        [LEN_W:0]       trial_sub;
    logic                        trial_ge;
    logic        [LEN_W-1:0]     rem_step;
    logic        [RAW_W-1:0]     q_low;
    logic        [RAW_W-1:0]     q_neg;
    logic signed [RAW_W-1:0]     result;

    // calibration: running sum, bias is sum >> 9 wrapped to 16 bits
    assign cal_sum_next = (ctrl.cal_clear ? '0 : cal_sum_reg) + CAL_SUM_W'(raw);

    // glitch clamp against previous output
    assign diff    = raw_reg - bias_reg;
    assign diff_x  = (RAW_W+2)'(diff);
    assign lo      = (RAW_W+2)'(prev_reg) - (RAW_W+2)'(GLITCH_LIMIT);
    assign hi      = (RAW_W+2)'(prev_reg) + (RAW_W+2)'(GLITCH_LIMIT);

    always_comb
    begin
        clamp_x = diff_x;
        if (diff_x < lo)
        begin
            clamp_x = lo;
        end
        if (clamp_x > hi)
        begin
            clamp_x = hi;
        end
    end

    gbga_ram #(
        .WIDTH (RAW_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.win_update),
        .waddr (win_addr),
        .wdata (v_reg),
        .re    (ctrl.clamp),
        .raddr (win_addr),
        .rdata (rdata)
    );

    // never-written slots read as zero
    assign old_val  = old_valid ? $signed(rdata) : '0;
    assign sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(v_reg);
    assign mag_full = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);

    // restoring divide, one quotient bit per cycle
    assign trial     = {rem_reg, dq_reg[MAG_W-1]};
    assign trial_ge  = trial >= {1'b0, len};
    assign trial_sub = trial - {1'b0, len};
    assign rem_step  = trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];

    assign q_low  = dq_reg[RAW_W-1:0];
    assign q_neg  = -q_low;
    assign result = ctrl.avg_on ? $signed(neg_reg ? q_neg : q_low) : v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sum_reg <= '0;
            bias_reg    <= '0;
            prev_reg    <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (ctrl.cal_load)
            begin
                cal_sum_reg <= cal_sum_next;
                bias_reg    <= cal_sum_next[CAL_SHIFT+RAW_W-1:CAL_SHIFT];
            end
            if (ctrl.win_update)
            begin
                sum_reg <= sum_next;
            end
            if (ctrl.finish)
            begin
                prev_reg <= result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            raw_reg <= raw;
        end
        if (ctrl.clamp)
        begin
            v_reg <= clamp_x[RAW_W-1:0];
        end
        if (ctrl.win_update)
        begin
            dq_reg  <= mag_full[MAG_W-1:0];
            neg_reg <= sum_next[SUM_W-1];
            rem_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            dq_reg  <= {dq_reg[MAG_W-2:0], trial_ge};
            rem_reg <= rem_step;
        end
    end

    assign rate = prev_reg;

endmodule

`default_nettype wire

### rtl/gbga_merge.sv
// ----------------------------------------------------------------------------
// gbga_merge
// Combines the lane results: optional 45 degree rotation of roll/pitch and
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbga_merge (
    input  var logic                              clk,
    input  var logic                              rst_n,
    input  var logic                              load_rot,
    input  var logic                              load_out,
    input  var gbga_pkg::rot_mode_t               rotate_mode,
    input  var logic signed [gbga_pkg::RAW_W-1:0] roll,
    input  var logic signed [gbga_pkg::RAW_W-1:0] pitch,
    input  var logic signed [gbga_pkg::RAW_W-1:0] yaw,
    input  var logic                              calibrating,
    input  var logic                              out_ready,
    output logic                                  out_valid,
    output gbga_pkg::out_word_t                   out_data
);
    import gbga_pkg::*;

    localparam int SUM_W   = RAW_W + 1;
    localparam int PROD_W  = RAW_W + 4;
    localparam int MAG_W   = RAW_W + 3;
    localparam int RECIP_W = 20;
    localparam int MUL_W   = MAG_W + RECIP_W;

    logic signed [SUM_W-1:0]  a_src;
    logic signed [SUM_W-1:0]  b_src;
    logic                     rot_on;
    logic signed [PROD_W-1:0] a_prod;
    logic signed [PROD_W-1:0] b_prod;
    logic        [PROD_W-1:0] a_abs;
    logic        [PROD_W-1:0] b_abs;

    logic        [MAG_W-1:0]  a_mag_reg;
    logic        [MAG_W-1:0]  b_mag_reg;
    logic                     a_neg_reg;
    logic                     b_neg_reg;
    logic                     rot_on_reg;
    logic signed [RAW_W-1:0]  roll_reg;
    logic signed [RAW_W-1:0]  pitch_reg;
    logic signed [RAW_W-1:0]  yaw_reg;
    logic                     cal_reg;

    logic        [MUL_W-1:0]  a_mul;
    logic        [MUL_W-1:0]  b_mul;
    logic        [RAW_W-1:0]  a_q;
    logic        [RAW_W-1:0]  b_q;
    logic        [RAW_W-1:0]  a_res;
    logic        [RAW_W-1:0]  b_res;

    out_word_t                out_data_reg;
    logic                     out_valid_reg;

    always_comb
    begin
        rot_on = 1'b1;
        a_src  = SUM_W'(roll) + SUM_W'(pitch);
        b_src  = SUM_W'(pitch) - SUM_W'(roll);
        unique case (rotate_mode)
            ROT_LEFT:
            begin
                a_src = SUM_W'(roll) + SUM_W'(pitch);
                b_src = SUM_W'(pitch) - SUM_W'(roll);
            end
            ROT_RIGHT:
            begin
                a_src = SUM_W'(roll) - SUM_W'(pitch);
                b_src = SUM_W'(pitch) + SUM_W'(roll);
            end
            default:
            begin
                rot_on = 1'b0;
            end
        endcase
    end

    assign a_prod = PROD_W'(a_src) * PROD_W'(ROT_NUM);
    assign b_prod = PROD_W'(b_src) * PROD_W'(ROT_NUM);
    assign a_abs  = a_prod[PROD_W-1] ? PROD_W'(-a_prod) : PROD_W'(a_prod);
    assign b_abs  = b_prod[PROD_W-1] ? PROD_W'(-b_prod) : PROD_W'(b_prod);

    always_ff @(posedge clk)
    begin
        if (load_rot)
        begin
            a_mag_reg  <= a_abs[MAG_W-1:0];
            b_mag_reg  <= b_abs[MAG_W-1:0];
            a_neg_reg  <= a_prod[PROD_W-1];
            b_neg_reg  <= b_prod[PROD_W-1];
            rot_on_reg <= rot_on;
            roll_reg   <= roll;
            pitch_reg  <= pitch;
            yaw_reg    <= yaw;
            cal_reg    <= calibrating;
        end
    end

    // magnitude / 10 by reciprocal, truncating toward zero via sign-magnitude
    assign a_mul = MUL_W'(a_mag_reg) * MUL_W'(ROT_RECIP);
    assign b_mul = MUL_W'(b_mag_reg) * MUL_W'(ROT_RECIP);
    assign a_q   = a_mul[ROT_SHIFT+RAW_W-1:ROT_SHIFT];
    assign b_q   = b_mul[ROT_SHIFT+RAW_W-1:ROT_SHIFT];
    assign a_res = a_neg_reg ? RAW_W'(-a_q) : a_q;
    assign b_res = b_neg_reg ? RAW_W'(-b_q) : b_q;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.rate_roll   <= rot_on_reg ? $signed(a_res) : roll_reg;
            out_data_reg.rate_pitch  <= rot_on_reg ? $signed(b_res) : pitch_reg;
            out_data_reg.rate_yaw    <= yaw_reg;
            out_data_reg.calibrating <= cal_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/gyro_bias_glitch_average_unit.sv
// ----------------------------------------------------------------------------
// gyro_bias_glitch_average_unit
// Three-axis gyro conditioning: bias calibration, glitch clamp, moving
// average and 45 degree rotation, one lane per axis.
// ----------------------------------------------------------------------------
// Averaging off: accept, clamp, finish, ROT1, then ROT2 loads the output register.
// Averaging on: the window index modulo runs before the clamp, and the window
//   update and the bit-serial divider in each lane run between clamp and finish.
// One word in flight; the next is taken while a result waits in the output.
// Reset clears control and lane accumulator state at once, window slots via valid bits: no sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gyro_bias_glitch_average_unit_assert.svh"

module gyro_bias_glitch_average_unit #(
    parameter int WINDOW_DEPTH = gbga_pkg::WINDOW_DEPTH_DEF
) (
    input  var logic                                  clk,
    input  var logic                                  rst_n,
    input  var logic                                  in_valid,
    output logic                                      in_ready,
    input  var gbga_pkg::in_word_t                    in_data,
    output logic                                      out_valid,
    input  var logic                                  out_ready,
    output gbga_pkg::out_word_t                       out_data,
    input  var logic                                  cfg_write,
    input  var logic [gbga_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  var logic [gbga_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gbga_pkg::*;

    localparam int ADDR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LEN_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int MAG_W     = RAW_W + $clog2(WINDOW_DEPTH);
    localparam int DIV_CNT_W = $clog2(MAG_W);
    localparam int MOD_CNT_W = (LEN_W > 1) ? $clog2(LEN_W) : 1;

    // configuration
    logic                    average_enable_reg;
    logic [AVG_LEN_W-1:0]    average_length_reg;
    rot_mode_t               rotate_mode_reg;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CAL_CNT_W-1:0]    cal_count_reg;
    logic [CAL_CNT_W-1:0]    cal_count_next;
    logic [CAL_CNT_W-1:0]    cal_eff;
    logic                    cal_active;
    logic                    calibrating_reg;
    logic [LEN_W-1:0]        window_index_reg;
    logic [LEN_W-1:0]        window_index_next;
    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic [LEN_W-1:0]        len_eff;
    logic [LEN_W-1:0]        num_reg;
    logic [LEN_W-1:0]        num_next;
    logic [LEN_W-1:0]        rem_reg;
    logic [LEN_W-1:0]        rem_next;
    logic [MOD_CNT_W-1:0]    mod_cnt_reg;
    logic [MOD_CNT_W-1:0]    mod_cnt_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_next;
    logic [WINDOW_DEPTH-1:0] win_valid_reg;

    logic                    accept;
    logic                    win_set;
    logic                    load_rot;
    logic                    load_out;
    lane_ctrl_t              lane_ctrl;
    logic [ADDR_W-1:0]       win_addr;
    logic                    old_valid;

    logic [LEN_W:0]          mod_trial;
    logic [LEN_W:0]          mod_sub;
    logic                    mod_ge;
    logic [LEN_W-1:0]        mod_rem;

    logic signed [RAW_W-1:0] rate_roll;
    logic signed [RAW_W-1:0] rate_pitch;
    logic signed [RAW_W-1:0] rate_yaw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_enable_reg <= 1'b0;
            average_length_reg <= AVG_LEN_W'(AVG_LEN_RESET);
            rotate_mode_reg    <= ROT_NONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_AVG_ENABLE:  average_enable_reg <= cfg_data[0];
                CFG_AVG_LENGTH:  average_length_reg <= cfg_data[AVG_LEN_W-1:0];
                CFG_ROTATE_MODE: rotate_mode_reg    <= rot_mode_t'(cfg_data[ROT_MODE_W-1:0]);
                default:         ;
            endcase
        end
    end

    // length used as 1 when zero, capped at window depth
    always_comb
    begin
        if (average_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (int'(average_length_reg) > WINDOW_DEPTH)
        begin
            len_eff = LEN_W'(WINDOW_DEPTH);
        end
        else
        begin
            len_eff = LEN_W'(average_length_reg);
        end
    end

    assign accept     = in_valid && in_ready;
    assign cal_eff    = in_data.start_calibration ? CAL_CNT_W'(CAL_SAMPLES) : cal_count_reg;
    assign cal_active = cal_eff != '0;
    assign cal_count_next = cal_active ? cal_eff - 1'b1 : cal_eff;

    // window index modulo, one bit per cycle
    assign mod_trial = {rem_reg, num_reg[LEN_W-1]};
    assign mod_ge    = mod_trial >= {1'b0, len_reg};
    assign mod_sub   = mod_trial - {1'b0, len_reg};
    assign mod_rem   = mod_ge ? mod_sub[LEN_W-1:0] : mod_trial[LEN_W-1:0];

    assign win_addr  = window_index_reg[ADDR_W-1:0];
    assign old_valid = win_valid_reg[win_addr];

    always_comb
    begin
        state_next        = state_reg;
        in_ready          = 1'b0;
        lane_ctrl         = '0;
        lane_ctrl.avg_on  = average_enable_reg;
        window_index_next = window_index_reg;
        len_next          = len_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        mod_cnt_next      = mod_cnt_reg;
        div_cnt_next      = div_cnt_reg;
        win_set           = 1'b0;
        load_rot          = 1'b0;
        load_out          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    lane_ctrl.accept    = 1'b1;
                    lane_ctrl.cal_load  = cal_active;
                    lane_ctrl.cal_clear = cal_eff == CAL_CNT_W'(CAL_SAMPLES);
                    len_next            = len_eff;
                    num_next            = window_index_reg + 1'b1;
                    rem_next            = '0;
                    mod_cnt_next        = '0;
                    state_next          = average_enable_reg ? ST_MOD : ST_CLAMP;
                end
            end
            ST_MOD:
            begin
                num_next = num_reg << 1;
                rem_next = mod_rem;
                if (mod_cnt_reg == MOD_CNT_W'(LEN_W - 1))
                begin
                    window_index_next = mod_rem;
                    state_next        = ST_CLAMP;
                end
                else
                begin
                    mod_cnt_next = mod_cnt_reg + 1'b1;
                end
            end
            ST_CLAMP:
            begin
                lane_ctrl.clamp = 1'b1;
                state_next      = average_enable_reg ? ST_UPD : ST_FIN;
            end
            ST_UPD:
            begin
                lane_ctrl.win_update = 1'b1;
                win_set              = 1'b1;
                div_cnt_next         = '0;
                state_next           = ST_DIV;
            end
            ST_DIV:
            begin
                lane_ctrl.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(MAG_W - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                lane_ctrl.finish = 1'b1;
                state_next       = ST_ROT1;
            end
            ST_ROT1:
            begin
                load_rot   = 1'b1;
                state_next = ST_ROT2;
            end
            ST_ROT2:
            begin
                if (!out_valid || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cal_count_reg    <= '0;
            calibrating_reg  <= 1'b0;
            window_index_reg <= '0;
            len_reg          <= LEN_W'(1);
            num_reg          <= '0;
            rem_reg          <= '0;
            mod_cnt_reg      <= '0;
            div_cnt_reg      <= '0;
            win_valid_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            window_index_reg <= window_index_next;
            len_reg          <= len_next;
            num_reg          <= num_next;
            rem_reg          <= rem_next;
            mod_cnt_reg      <= mod_cnt_next;
            div_cnt_reg      <= div_cnt_next;
            if (accept)
            begin
                cal_count_reg   <= cal_count_next;
                calibrating_reg <= cal_count_next != '0;
            end
            if (win_set)
            begin
                win_valid_reg[win_addr] <= 1'b1;
            end
        end
    end

    gbga_lane #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .raw       (in_data.raw_roll),
        .len       (len_reg),
        .win_addr  (win_addr),
        .old_valid (old_valid),
        .rate      (rate_roll)
    );

    gbga_lane #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .raw       (in_data.raw_pitch),
        .len       (len_reg),
        .win_addr  (win_addr),
        .old_valid (old_valid),
        .rate      (rate_pitch)
    );

    gbga_lane #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .raw       (in_data.raw_yaw),
        .len       (len_reg),
        .win_addr  (win_addr),
        .old_valid (old_valid),
        .rate      (rate_yaw)
    );

    gbga_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_rot    (load_rot),
        .load_out    (load_out),
        .rotate_mode (rotate_mode_reg),
        .roll        (rate_roll),
        .pitch       (rate_pitch),
        .yaw         (rate_yaw),
        .calibrating (calibrating_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

    // window slot must lie inside the current length when it is updated
    `GBGA_ASSERT_IMP(a_index_in_len, clk, rst_n, state_reg == ST_UPD, window_index_reg < len_reg)
    // a new output word only ever comes from the final rotation step
    `GBGA_ASSERT_IMP(a_out_source, clk, rst_n, $rose(out_valid), $past(state_reg == ST_ROT2))
    // calibration counter never exceeds the sample count
    `GBGA_ASSERT_IMP(a_cal_range, clk, rst_n, 1'b1, cal_count_reg <= CAL_CNT_W'(CAL_SAMPLES))
    // with averaging off the window path is skipped entirely
    `GBGA_ASSERT_NXT(a_skip_window, clk, rst_n, accept && !average_enable_reg, state_reg == ST_CLAMP)

endmodule

`default_nettype wire

### dv/gbga_rate_checker.sv
// ----------------------------------------------------------------------------
// gbga_rate_checker
// Watches the sample, result and register ports of the gyro conditioning
// unit, predicts each conditioned word from the accepted samples and
// compares the results field by field, in order.
// ----------------------------------------------------------------------------
module gbga_rate_checker #(
    parameter int WINDOW_DEPTH = gbga_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  gbga_pkg::in_word_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  gbga_pkg::out_word_t             out_data,
    input  logic                            cfg_write,
    input  logic [gbga_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbga_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                     fail_count,
    output int unsigned                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gbga_pkg::*;

    localparam int ROT_DIV = 10;

    logic                    avg_on;
    logic [AVG_LEN_W-1:0]    avg_len;
    logic [ROT_MODE_W-1:0]   rot_sel;
    logic [CAL_CNT_W-1:0]    cal_left;
    logic [CAL_SUM_W-1:0]    cal_acc [3];
    logic signed [RAW_W-1:0] bias_est [3];
    logic signed [RAW_W-1:0] last_rate [3];
    logic signed [RAW_W-1:0] window [3][WINDOW_DEPTH];
    int                      window_total [3];
    int                      window_pos;
    out_word_t               rate_q [$];
    int unsigned             errors = 0;

    assign fail_count = errors;

    function automatic int fold16(input int x);
        logic signed [RAW_W-1:0] s;
        s = x[RAW_W-1:0];
        return s;
    endfunction

    task automatic clear_model();
        avg_on     = 1'b0;
        avg_len    = AVG_LEN_W'(AVG_LEN_RESET);
        rot_sel    = ROT_NONE;
        cal_left   = '0;
        window_pos = 0;
        for (int a = 0; a < 3; a++)
        begin
            cal_acc[a]      = '0;
            bias_est[a]     = '0;
            last_rate[a]    = '0;
            window_total[a] = 0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                window[a][i] = '0;
        end
        rate_q.delete();
    endtask

    task automatic condition_sample(input in_word_t w);
        int        raw [3];
        int        rate [3];
        int        v;
        int        lo;
        int        hi;
        int        len;
        int        t;
        out_word_t want;
        raw[0] = w.raw_roll;
        raw[1] = w.raw_pitch;
        raw[2] = w.raw_yaw;

        if (w.start_calibration)
            cal_left = CAL_CNT_W'(CAL_SAMPLES);
        if (cal_left != 0)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (cal_left == CAL_SAMPLES)
                    cal_acc[a] = '0;
                cal_acc[a]  = cal_acc[a] + raw[a];
                // bias is floor(sum / 512) of the running sum
                bias_est[a] = RAW_W'($signed(cal_acc[a]) >>> CAL_SHIFT);
            end
            cal_left = cal_left - 1'b1;
        end

        len = avg_len;
        if (len < 1)
            len = 1;
        if (len > WINDOW_DEPTH)
            len = WINDOW_DEPTH;
        if (avg_on)
            window_pos = (window_pos + 1) % len;

        for (int a = 0; a < 3; a++)
        begin
            v  = fold16(raw[a] - bias_est[a]);
            lo = last_rate[a] - GLITCH_LIMIT;
            hi = last_rate[a] + GLITCH_LIMIT;
            if (v < lo)
                v = lo;
            if (v > hi)
                v = hi;
            if (avg_on)
            begin
                // slots outside a shortened window stay in the total
                window_total[a] -= window[a][window_pos % WINDOW_DEPTH];
                window[a][window_pos % WINDOW_DEPTH] = RAW_W'(v);
                window_total[a] += v;
                v = fold16(window_total[a] / len);
            end
            last_rate[a] = RAW_W'(v);
            rate[a]      = v;
        end

        if (rot_sel == ROT_LEFT)
        begin
            t       = fold16((rate[1] - rate[0]) * ROT_NUM / ROT_DIV);
            rate[0] = fold16((rate[0] + rate[1]) * ROT_NUM / ROT_DIV);
            rate[1] = t;
        end
        else if (rot_sel == ROT_RIGHT)
        begin
            t       = fold16((rate[1] + rate[0]) * ROT_NUM / ROT_DIV);
            rate[0] = fold16((rate[0] - rate[1]) * ROT_NUM / ROT_DIV);
            rate[1] = t;
        end

        want.rate_roll   = RAW_W'(rate[0]);
        want.rate_pitch  = RAW_W'(rate[1]);
        want.rate_yaw    = RAW_W'(rate[2]);
        want.calibrating = (cal_left != 0);
        rate_q.push_back(want);
    endtask

    task automatic note_mismatch(input string field, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (rate_q.size() == 0)
        begin
            errors++;
            $display("%0t: result word with none expected, expected nothing, got %p",
                     $time, got);
        end
        else
        begin
            want = rate_q.pop_front();
            if (got.rate_roll !== want.rate_roll)
                note_mismatch("rate_roll", want.rate_roll, got.rate_roll);
            if (got.rate_pitch !== want.rate_pitch)
                note_mismatch("rate_pitch", want.rate_pitch, got.rate_pitch);
            if (got.rate_yaw !== want.rate_yaw)
                note_mismatch("rate_yaw", want.rate_yaw, got.rate_yaw);
            if (got.calibrating !== want.calibrating)
                note_mismatch("calibrating", want.calibrating, got.calibrating);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_AVG_ENABLE:  avg_on  = cfg_data[0];
                    CFG_AVG_LENGTH:  avg_len = cfg_data[AVG_LEN_W-1:0];
                    CFG_ROTATE_MODE: rot_sel = cfg_data[ROT_MODE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                condition_sample(in_data);
            if (out_valid && out_ready)
                check_result(out_data);
            pending <= rate_q.size();
        end
    end

endmodule

### dv/gyro_bias_glitch_average_unit_tb.sv
// ----------------------------------------------------------------------------
// gyro_bias_glitch_average_unit_tb
// Drives gyro sample words through the conditioning unit under a run of
// register settings: a short directed set, then bursts of steady, noisy and
// full-scale samples, with a randomly stalling result side. The checker
// beside the unit scores every result word.
// ----------------------------------------------------------------------------
module gyro_bias_glitch_average_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbga_pkg::*;

    localparam int                   CYCLE_LIMIT    = 600_000;
    localparam int                   SETTLE_CYCLES  = 64;
    localparam int                   PHASE_WORDS    = 130;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [1:0]           ROT_SPARE      = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int unsigned           fail_count;
    int unsigned           pending;
    int unsigned           cycle_count = 0;
    int unsigned           ready_hold  = 0;
    int unsigned           ready_style = 0;

    gyro_bias_glitch_average_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gbga_rate_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gyro_bias_glitch_average_unit verification failed");
            $finish;
        end
    end

    // result side: a new stall style after each random hold
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_hold  <= $urandom_range(20, 120);
            ready_style <= $urandom_range(0, 3);
        end
        else
            ready_hold <= ready_hold - 1;
        unique case (ready_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= (ready_hold[2:0] < 3'd3);
        endcase
    end

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int rail();
        unique case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int any_level();
        logic signed [RAW_W-1:0] s;
        s = RAW_W'($urandom());
        return s;
    endfunction

    function automatic in_word_t gyro_word(input bit cal, input int r, input int p,
                                           input int y);
        in_word_t w;
        w.start_calibration = cal;
        w.raw_roll          = RAW_W'(r);
        w.raw_pitch         = RAW_W'(p);
        w.raw_yaw           = RAW_W'(y);
        return w;
    endfunction

    // mostly a steady rate with sensor noise, some glitches and full-scale junk
    function automatic in_word_t make_sample(input bit cal, input int br, input int bp,
                                             input int by);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return gyro_word(cal, br + jitter(40), bp + jitter(40), by + jitter(40));
        else if (pick < 75)
            return gyro_word(cal, br + jitter(1500), bp + jitter(1500), by + jitter(1500));
        else if (pick < 90)
            return gyro_word(cal, any_level(), any_level(), any_level());
        else
            return gyro_word(cal, rail(), rail(), rail());
    endfunction

    task automatic push_sample(input in_word_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic run_phase(input bit en, input int len, input logic [1:0] rot,
                             input bit fixed_base, input int base, input bit force_cal,
                             input bit poke_unused);
        int base_r;
        int base_p;
        int base_y;
        int sent;
        int burst;
        bit cal;
        wait_quiet();
        write_reg(CFG_AVG_ENABLE, en);
        write_reg(CFG_AVG_LENGTH, len);
        write_reg(CFG_ROTATE_MODE, rot);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, $urandom_range(0, 15));
        cfg_write <= 1'b0;

        if (fixed_base)
        begin
            base_r = base;
            base_p = -base;
            base_y = base / 2;
        end
        else
        begin
            base_r = any_level();
            base_p = any_level();
            base_y = any_level();
        end

        sent = 0;
        while (sent < PHASE_WORDS)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < PHASE_WORDS; k++)
            begin
                cal = (force_cal && sent == 0) || ($urandom_range(0, 1999) == 0);
                push_sample(make_sample(cal, base_r, base_p, base_y));
                sent++;
            end
            idle_for($urandom_range(1, 40));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset register values
        push_sample(gyro_word(1'b0, 0, 0, 0));
        push_sample(gyro_word(1'b0, 32767, 32767, 32767));
        push_sample(gyro_word(1'b0, -32768, -32768, -32768));
        push_sample(gyro_word(1'b0, 32767, -32768, 0));
        idle_for(3);
        // calibration on a negative sum
        push_sample(gyro_word(1'b1, -32768, -32768, -32768));
        push_sample(gyro_word(1'b0, -32768, 32767, -1));
        push_sample(gyro_word(1'b0, 21845, -21846, 21845));
        push_sample(gyro_word(1'b0, -21846, 21845, -21846));
        idle_for(17);
        // restart part way through calibration
        push_sample(gyro_word(1'b1, 1000, -1000, 5));
        push_sample(gyro_word(1'b0, -1, 1, 800));
        push_sample(gyro_word(1'b0, 801, -801, -800));
        push_sample(gyro_word(1'b0, 1, -1, 0));
        push_sample(gyro_word(1'b1, 32767, 32767, 32767));
        push_sample(gyro_word(1'b0, 32767, -32768, 32767));

        run_phase(1'b1, 8,  ROT_LEFT,  1'b1, 32700, 1'b0, 1'b1);
        // length 1 over a full window of large entries: quotient wraps
        run_phase(1'b1, 1,  ROT_RIGHT, 1'b0, 0,     1'b0, 1'b0);
        run_phase(1'b1, 0,  ROT_SPARE, 1'b0, 0,     1'b0, 1'b1);
        run_phase(1'b1, 15, ROT_NONE,  1'b0, 0,     1'b0, 1'b0);
        run_phase(1'b0, 5,  ROT_RIGHT, 1'b1, 32700, 1'b1, 1'b0);
        run_phase(1'b1, 3,  ROT_LEFT,  1'b0, 0,     1'b0, 1'b1);
        run_phase(1'b1, 2,  ROT_NONE,  1'b0, 0,     1'b0, 1'b0);
        run_phase(1'b0, 8,  ROT_LEFT,  1'b0, 0,     1'b0, 1'b0);

        wait_quiet();
        if (fail_count == 0 && pending == 0)
            $display("gyro_bias_glitch_average_unit verification clean");
        else
            $display("gyro_bias_glitch_average_unit verification failed");
        $finish;
    end

endmodule

### gyro_bias_glitch_average_unit.f
+incdir+rtl
rtl/gbga_pkg.sv
rtl/gbga_ram.sv
rtl/gbga_lane.sv
rtl/gbga_merge.sv
rtl/gyro_bias_glitch_average_unit.sv
dv/gbga_rate_checker.sv
dv/gyro_bias_glitch_average_unit_tb.sv
